### design/sqrot_pkg.sv
package sqrot_pkg;

  localparam int MaxSide  = 32;
  localparam int PixelW   = 8;
  localparam int SideRegW = 6;
  localparam int TurnsW   = 2;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = SideRegW;

  localparam logic [SideRegW-1:0] SideReset  = SideRegW'(28);

  typedef enum logic [CfgIdxW-1:0] {
    CfgSideLength   = 1'b0,
    CfgQuarterTurns = 1'b1
  } cfg_reg_e;

  typedef enum logic [TurnsW-1:0] {
    Rot0   = 2'd0,
    Rot90  = 2'd1,
    Rot180 = 2'd2,
    Rot270 = 2'd3
  } rot_e;

  localparam rot_e TurnsReset = Rot270;

  typedef enum logic {
    KindLoad  = 1'b0,
    KindDrain = 1'b1
  } kind_e;

endpackage

### design/sqrot_if.sv
interface sqrot_in_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [sqrot_pkg::PixelW-1:0] pixel_in;

  modport source (output valid, output kind, output pixel_in, input ready);
  modport sink   (input valid, input kind, input pixel_in, output ready);
endinterface

interface sqrot_out_if;
  logic                         valid;
  logic                         ready;
  logic [sqrot_pkg::PixelW-1:0] pixel_out;
  logic                         frame_end;

  modport source (output valid, output pixel_out, output frame_end, input ready);
  modport sink   (input valid, input pixel_out, input frame_end, output ready);
endinterface

interface sqrot_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [sqrot_pkg::CfgIdxW-1:0]  index;
  logic [sqrot_pkg::CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### design/square_image_quarter_turn_rotator.sv
// Rotates a square image of side_length pixels by quarter_turns clockwise quarter turns. Pixels
// enter in raster order, one transaction per clock, and each is written at its rotated place
// in one of two frame banks held in a single RAM of 2*MAX_SIDE*MAX_SIDE bytes. Every input
// transaction (load or drain) that arrives while a completed frame is pending also reads one
// pixel of that frame in destination raster order; the pixel passes through the RAM read
// register and then an output register, and frame_end marks the last pixel of a frame.
// Completing a new frame abandons the older one. The block sustains one transaction per cycle;
// input is stalled only while the output is held back or while a configuration write is offered,
// which takes precedence over input transactions.
// Writing either configuration register restarts loading and discards any completed frame.
module square_image_quarter_turn_rotator #(
  parameter int MAX_SIDE = sqrot_pkg::MaxSide
) (
  input  logic clk_i,
  input  logic rst_ni,
  sqrot_in_if.sink    in_i,
  sqrot_out_if.source out_o,
  sqrot_cfg_if.sink   cfg_i
);

  localparam int BankWords = MAX_SIDE * MAX_SIDE;
  localparam int RamDepth  = 2 * BankWords;
  localparam int AW        = $clog2(RamDepth);
  localparam int IW        = $clog2(BankWords);
  localparam int CW        = $clog2(MAX_SIDE);
  localparam int SW        = ($clog2(MAX_SIDE + 1) > sqrot_pkg::SideRegW) ?
                             $clog2(MAX_SIDE + 1) : sqrot_pkg::SideRegW;

  logic [sqrot_pkg::SideRegW-1:0] side_q, side_d;
  sqrot_pkg::rot_e                turns_q, turns_d;
  logic [CW-1:0]                  row_q, row_d, col_q, col_d;
  logic                           fill_bank_q, fill_bank_d;
  logic                           frame_ready_q, frame_ready_d;
  logic [IW-1:0]                  emit_idx_q, emit_idx_d;
  logic                           rd_pend_q, rd_pend_d;
  logic                           rd_end_q, rd_end_d;
  logic                           out_valid_q, out_valid_d;
  logic [sqrot_pkg::PixelW-1:0]   out_pix_q, out_pix_d;
  logic                           out_end_q, out_end_d;

  logic                           in_acc, cfg_acc, move, emit, load;
  logic [SW-1:0]                  side_ext, s, r_cl, c_cl, dr, dc;
  logic [2*SW-1:0]                area, wprod, ridx_ext;
  logic [IW-1:0]                  widx, ridx;
  logic                           last_pix;
  logic [AW-1:0]                  waddr, raddr;
  logic [sqrot_pkg::PixelW-1:0]   rdata;

  assign cfg_i.ready = 1'b1;
  assign cfg_acc     = cfg_i.valid & cfg_i.ready;

  assign move       = rd_pend_q & (~out_valid_q | out_o.ready);
  assign in_i.ready = (~rd_pend_q | move) & ~cfg_i.valid;
  assign in_acc     = in_i.valid & in_i.ready;
  assign emit       = in_acc & frame_ready_q;
  assign load       = in_acc & (sqrot_pkg::kind_e'(in_i.kind) == sqrot_pkg::KindLoad);

  assign out_o.valid     = out_valid_q;
  assign out_o.pixel_out = out_pix_q;
  assign out_o.frame_end = out_end_q;

  always_comb begin
    side_ext = SW'(side_q);
    if (side_q == '0) begin
      s = SW'(1);
    end else if (side_ext > SW'(MAX_SIDE)) begin
      s = SW'(MAX_SIDE);
    end else begin
      s = side_ext;
    end
    area = {{SW{1'b0}}, s} * {{SW{1'b0}}, s};

    r_cl = (SW'(row_q) >= s) ? s - SW'(1) : SW'(row_q);
    c_cl = (SW'(col_q) >= s) ? s - SW'(1) : SW'(col_q);

    case (turns_q)
      sqrot_pkg::Rot0: begin
        dr = r_cl;
        dc = c_cl;
      end
      sqrot_pkg::Rot90: begin
        dr = c_cl;
        dc = s - SW'(1) - r_cl;
      end
      sqrot_pkg::Rot180: begin
        dr = s - SW'(1) - r_cl;
        dc = s - SW'(1) - c_cl;
      end
      default: begin
        dr = s - SW'(1) - c_cl;
        dc = r_cl;
      end
    endcase
    wprod = {{SW{1'b0}}, dr} * {{SW{1'b0}}, s};
    widx  = IW'(wprod + (2*SW)'(dc));
    waddr = fill_bank_q ? AW'(BankWords) + AW'(widx) : AW'(widx);

    ridx_ext = ((2*SW)'(emit_idx_q) >= area) ? area - (2*SW)'(1) : (2*SW)'(emit_idx_q);
    ridx     = IW'(ridx_ext);
    last_pix = (ridx_ext == area - (2*SW)'(1));
    raddr    = fill_bank_q ? AW'(ridx) : AW'(BankWords) + AW'(ridx);
  end

  always_comb begin
    side_d        = side_q;
    turns_d       = turns_q;
    row_d         = row_q;
    col_d         = col_q;
    fill_bank_d   = fill_bank_q;
    frame_ready_d = frame_ready_q;
    emit_idx_d    = emit_idx_q;

    if (cfg_acc) begin
      case (sqrot_pkg::cfg_reg_e'(cfg_i.index))
        sqrot_pkg::CfgSideLength:   side_d  = cfg_i.data;
        sqrot_pkg::CfgQuarterTurns: turns_d = sqrot_pkg::rot_e'(cfg_i.data[sqrot_pkg::TurnsW-1:0]);
        default: ;
      endcase
      row_d         = '0;
      col_d         = '0;
      frame_ready_d = 1'b0;
      emit_idx_d    = '0;
    end else begin
      if (emit) begin
        if (last_pix) begin
          frame_ready_d = 1'b0;
          emit_idx_d    = '0;
        end else begin
          emit_idx_d = ridx + IW'(1);
        end
      end
      if (load) begin
        if (c_cl + SW'(1) < s) begin
          col_d = CW'(c_cl + SW'(1));
          row_d = CW'(r_cl);
        end else if (r_cl + SW'(1) < s) begin
          col_d = '0;
          row_d = CW'(r_cl + SW'(1));
        end else begin
          col_d         = '0;
          row_d         = '0;
          fill_bank_d   = ~fill_bank_q;
          frame_ready_d = 1'b1;
          emit_idx_d    = '0;
        end
      end
    end
  end

  always_comb begin
    rd_pend_d   = rd_pend_q;
    rd_end_d    = rd_end_q;
    out_valid_d = out_valid_q;
    out_pix_d   = out_pix_q;
    out_end_d   = out_end_q;

    if (move) begin
      out_valid_d = 1'b1;
      out_pix_d   = rdata;
      out_end_d   = rd_end_q;
      rd_pend_d   = 1'b0;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end

    if (emit) begin
      rd_pend_d = 1'b1;
      rd_end_d  = last_pix;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q        <= sqrot_pkg::SideReset;
      turns_q       <= sqrot_pkg::TurnsReset;
      row_q         <= '0;
      col_q         <= '0;
      fill_bank_q   <= 1'b0;
      frame_ready_q <= 1'b0;
      emit_idx_q    <= '0;
      rd_pend_q     <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      side_q        <= side_d;
      turns_q       <= turns_d;
      row_q         <= row_d;
      col_q         <= col_d;
      fill_bank_q   <= fill_bank_d;
      frame_ready_q <= frame_ready_d;
      emit_idx_q    <= emit_idx_d;
      rd_pend_q     <= rd_pend_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_end_q  <= rd_end_d;
    out_pix_q <= out_pix_d;
    out_end_q <= out_end_d;
  end

  sqrot_ram #(
    .Width (sqrot_pkg::PixelW),
    .Depth (RamDepth)
  ) u_banks (
    .clk_i   (clk_i),
    .we_i    (load),
    .waddr_i (waddr),
    .wdata_i (in_i.pixel_in),
    .re_i    (emit),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

endmodule

### design/sqrot_ram.sv
module sqrot_ram #(
  parameter int Width = 8,
  parameter int Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
